FILE: design/cantxq_pkg.sv
// Shared types and constants for the CAN transmit queue with completion slots.
// No dependencies; every other design file imports this package.
package cantxq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int SLOT_COUNT  = 2;

   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int SLOT_W = $clog2(SLOT_COUNT + 1);
   localparam int SIDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   localparam logic [SLOT_W-1:0] SLOT_NONE = SLOT_W'(SLOT_COUNT);

   localparam logic [15:0] EXPIRY_RESET = 16'd100;

   localparam logic [1:0] OUTCOME_OK   = 2'd0;
   localparam logic [1:0] OUTCOME_BUSY = 2'd1;

   localparam logic [1:0] CSR_TX_ENABLE      = 2'd0;
   localparam logic [1:0] CSR_DEVICE_PRESENT = 2'd1;
   localparam logic [1:0] CSR_EXPIRY_MS      = 2'd2;

   typedef enum logic [2:0] {
      KIND_SUBMIT      = 3'd0,
      KIND_SUBMIT_WAIT = 3'd1,
      KIND_SERVICE     = 3'd2,
      KIND_TIMEOUT     = 3'd3,
      KIND_READ        = 3'd4,
      KIND_BUS_RESET   = 3'd5
   } kind_type;

   typedef enum logic [3:0] {
      STAT_ACCEPTED    = 4'd0,
      STAT_TX_DISABLED = 4'd1,
      STAT_NO_DEVICE   = 4'd2,
      STAT_DROPPED     = 4'd3,
      STAT_BUSY        = 4'd4,
      STAT_IDLE        = 4'd5,
      STAT_DONE        = 4'd6,
      STAT_RETRY       = 4'd7,
      STAT_DISCARDED   = 4'd8,
      STAT_PENDING     = 4'd9,
      STAT_READY       = 4'd10,
      STAT_RESET       = 4'd11,
      STAT_TIMEOUT     = 4'd12
   } status_type;

   typedef enum logic [1:0] {
      SLOT_FREE      = 2'd0,
      SLOT_PEND      = 2'd1,
      SLOT_DONE      = 2'd2,
      SLOT_CANCELLED = 2'd3
   } slot_state_type;

   typedef enum logic [1:0] {
      RES_OK      = 2'd0,
      RES_TIMEOUT = 2'd1,
      RES_RESET   = 2'd2
   } res_type;

   typedef struct packed {
      kind_type          kind;
      logic [28:0]       can_id;
      logic              is_extended;
      logic [3:0]        dlc;
      logic [63:0]       payload;
      logic [SLOT_W-1:0] slot_held;
      logic [1:0]        mailbox_outcome;
      logic [31:0]       now_ms;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [SLOT_W-1:0] slot_given;
      logic [1:0]        completion_code;
      logic              attempt_made;
      logic [28:0]       frame_id;
      logic              frame_extended;
      logic [3:0]        frame_dlc;
      logic [63:0]       frame_payload;
      logic [31:0]       drops;
      logic [CNT_W-1:0]  queue_level;
   } rsp_type;

   typedef struct packed {
      logic [28:0]       id;
      logic              ext;
      logic [3:0]        dlc;
      logic [SLOT_W-1:0] slot;
      logic [63:0]       data;
   } frame_type;

   typedef struct packed {
      logic        tx_enable;
      logic        device_present;
      logic [15:0] expiry_ms;
   } cfg_type;

   typedef struct packed {
      logic      push;
      logic      pop;
      logic      clear;
      frame_type push_frame;
   } fifo_cmd_type;

   typedef struct packed {
      frame_type        head;
      logic [CNT_W-1:0] count;
   } fifo_stat_type;

endpackage

FILE: design/cantxq_csr.sv
// Configuration registers: transmit enable, device present, expiry interval.
// Depends on cantxq_pkg.
module cantxq_csr import cantxq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_TX_ENABLE:      cfg_in.tx_enable      = csr_data[0];
            CSR_DEVICE_PRESENT: cfg_in.device_present = csr_data[0];
            CSR_EXPIRY_MS:      cfg_in.expiry_ms      = csr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tx_enable      <= 1'b0;
         cfg_ff.device_present <= 1'b0;
         cfg_ff.expiry_ms      <= EXPIRY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: design/cantxq_fifo.sv
// Frame FIFO: entry storage in flops with a mux read of the head, pointers and fill count.
// Depends on cantxq_pkg.
module cantxq_fifo import cantxq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  fifo_cmd_type  cmd,
   output fifo_stat_type stat
);

   frame_type        entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (cmd.clear) begin
         rd_ptr_in = '0;
         wr_ptr_in = '0;
         count_in  = '0;
      end else if (cmd.push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         count_in  = count_ff + 1'b1;
      end else if (cmd.pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         count_in  = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push && !cmd.clear) begin
         entry_ff[wr_ptr_ff] <= cmd.push_frame;
      end
   end

   assign stat.head  = entry_ff[rd_ptr_ff];
   assign stat.count = count_ff;

endmodule

FILE: design/cantxq_ctrl.sv
// Queue control: submit/service/slot decisions, in-flight frame, slot table, drop count.
// Depends on cantxq_pkg; drives cantxq_fifo through a command struct.
module cantxq_ctrl import cantxq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          fire,
   input  req_type       item,
   input  cfg_type       cfg,
   input  fifo_stat_type fifo_stat,
   output fifo_cmd_type  fifo_cmd,
   output rsp_type       result
);

   frame_type      flight_ff, flight_in;
   logic           flight_valid_ff, flight_valid_in;
   logic [31:0]    flight_start_ff, flight_start_in;
   slot_state_type slot_state_ff [SLOT_COUNT];
   slot_state_type slot_state_in [SLOT_COUNT];
   res_type        slot_result_ff [SLOT_COUNT];
   res_type        slot_result_in [SLOT_COUNT];
   logic [31:0]    drop_ff, drop_in;

   frame_type         norm;
   frame_type         cur;
   frame_type         shown;
   logic [31:0]       cur_start;
   logic [31:0]       elapsed;
   logic              expired;
   logic              busy;
   res_type           res;
   logic              cur_has_slot;
   logic [SIDX_W-1:0] cur_idx;
   logic [SIDX_W-1:0] held_idx;
   logic              free_found;
   logic [SIDX_W-1:0] free_idx;
   logic              do_drop;
   status_type        status;
   logic [SLOT_W-1:0] slot_out;
   res_type           code;
   logic              attempt;
   logic [CNT_W-1:0]  level;

   // incoming frame: standard ids keep 11 bits, length saturates at 8
   always_comb begin
      norm.ext  = item.is_extended;
      norm.id   = item.is_extended ? item.can_id : {18'd0, item.can_id[10:0]};
      norm.dlc  = (item.dlc > 4'd8) ? 4'd8 : item.dlc;
      norm.slot = SLOT_NONE;
      norm.data = item.payload;
   end

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (slot_state_ff[i] == SLOT_FREE) begin
            free_found = 1'b1;
            free_idx   = SIDX_W'(i);
         end
      end
   end

   // frame under service: held one, else the queue head stamped with now
   always_comb begin
      cur          = flight_valid_ff ? flight_ff : fifo_stat.head;
      cur_start    = flight_valid_ff ? flight_start_ff : item.now_ms;
      cur_has_slot = (cur.slot < SLOT_W'(SLOT_COUNT));
      cur_idx      = cur.slot[SIDX_W-1:0];
      held_idx     = item.slot_held[SIDX_W-1:0];
      elapsed      = item.now_ms - cur_start;
      expired      = (elapsed >= {16'd0, cfg.expiry_ms});
   end

   always_comb begin
      flight_in       = flight_ff;
      flight_valid_in = flight_valid_ff;
      flight_start_in = flight_start_ff;
      slot_state_in   = slot_state_ff;
      slot_result_in  = slot_result_ff;
      fifo_cmd        = '0;
      fifo_cmd.push_frame = norm;
      do_drop  = 1'b0;
      status   = STAT_IDLE;
      slot_out = SLOT_NONE;
      code     = RES_OK;
      attempt  = 1'b0;
      shown    = '0;
      busy     = 1'b0;
      res      = RES_RESET;

      unique case (item.kind)
         KIND_SUBMIT, KIND_SUBMIT_WAIT: begin
            if (!cfg.tx_enable) begin
               status = STAT_TX_DISABLED;
            end else if (!cfg.device_present) begin
               status = STAT_NO_DEVICE;
            end else if (fifo_stat.count == CNT_W'(QUEUE_DEPTH)) begin
               do_drop = 1'b1;
               status  = STAT_DROPPED;
            end else if (item.kind == KIND_SUBMIT) begin
               fifo_cmd.push = 1'b1;
               status        = STAT_ACCEPTED;
            end else if (free_found) begin
               slot_state_in[free_idx]  = SLOT_PEND;
               fifo_cmd.push_frame.slot = SLOT_W'(free_idx);
               fifo_cmd.push            = 1'b1;
               status                   = STAT_ACCEPTED;
               slot_out                 = SLOT_W'(free_idx);
            end else begin
               do_drop = 1'b1;
               status  = STAT_BUSY;
            end
         end
         KIND_SERVICE: begin
            if (flight_valid_ff || fifo_stat.count != '0) begin
               if (!flight_valid_ff) begin
                  fifo_cmd.pop    = 1'b1;
                  flight_in       = fifo_stat.head;
                  flight_valid_in = 1'b1;
                  flight_start_in = item.now_ms;
               end
               if (cur_has_slot && slot_state_ff[cur_idx] == SLOT_CANCELLED) begin
                  flight_valid_in        = 1'b0;
                  slot_state_in[cur_idx] = SLOT_FREE;
                  slot_out               = cur.slot;
                  status                 = STAT_DISCARDED;
               end else begin
                  res = expired ? RES_TIMEOUT : RES_RESET;
                  if (!expired && cfg.tx_enable && cfg.device_present) begin
                     attempt = 1'b1;
                     shown   = cur;
                     case (item.mailbox_outcome)
                        OUTCOME_OK:   res  = RES_OK;
                        OUTCOME_BUSY: busy = 1'b1;
                        default:      res  = RES_RESET;
                     endcase
                  end
                  if (busy) begin
                     status = STAT_RETRY;
                  end else begin
                     flight_valid_in = 1'b0;
                     status          = STAT_DONE;
                     code            = res;
                     if (cur_has_slot) begin
                        slot_out = cur.slot;
                        if (slot_state_ff[cur_idx] == SLOT_PEND) begin
                           slot_result_in[cur_idx] = res;
                           slot_state_in[cur_idx]  = SLOT_DONE;
                        end else if (slot_state_ff[cur_idx] == SLOT_CANCELLED) begin
                           slot_state_in[cur_idx] = SLOT_FREE;
                        end
                     end
                  end
               end
            end
         end
         KIND_TIMEOUT, KIND_READ: begin
            if (item.slot_held < SLOT_W'(SLOT_COUNT)
                && slot_state_ff[held_idx] != SLOT_FREE) begin
               slot_out = item.slot_held;
               case (slot_state_ff[held_idx])
                  SLOT_DONE: begin
                     status                  = STAT_READY;
                     code                    = slot_result_ff[held_idx];
                     slot_state_in[held_idx] = SLOT_FREE;
                  end
                  SLOT_CANCELLED: status = STAT_TIMEOUT;
                  default: begin
                     if (item.kind == KIND_TIMEOUT) begin
                        slot_state_in[held_idx] = SLOT_CANCELLED;
                        status                  = STAT_TIMEOUT;
                     end else begin
                        status = STAT_PENDING;
                     end
                  end
               endcase
            end
         end
         KIND_BUS_RESET: begin
            fifo_cmd.clear  = 1'b1;
            flight_valid_in = 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (slot_state_ff[i] == SLOT_PEND) begin
                  slot_result_in[i] = RES_RESET;
                  slot_state_in[i]  = SLOT_DONE;
               end else if (slot_state_ff[i] == SLOT_CANCELLED) begin
                  slot_state_in[i] = SLOT_FREE;
               end
            end
            status = STAT_RESET;
         end
         default: status = STAT_IDLE;
      endcase

      // queue moves only on the cycle the item is consumed
      if (!fire) begin
         fifo_cmd.push  = 1'b0;
         fifo_cmd.pop   = 1'b0;
         fifo_cmd.clear = 1'b0;
      end

      drop_in = (do_drop && drop_ff != '1) ? drop_ff + 32'd1 : drop_ff;
   end

   // fill level after this item
   always_comb begin
      if (fifo_cmd.clear) begin
         level = '0;
      end else if (fifo_cmd.push) begin
         level = fifo_stat.count + 1'b1;
      end else if (fifo_cmd.pop) begin
         level = fifo_stat.count - 1'b1;
      end else begin
         level = fifo_stat.count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flight_valid_ff <= 1'b0;
         flight_start_ff <= '0;
         drop_ff         <= '0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_state_ff[i]  <= SLOT_FREE;
            slot_result_ff[i] <= RES_TIMEOUT;
         end
      end else if (fire) begin
         flight_valid_ff <= flight_valid_in;
         flight_start_ff <= flight_start_in;
         drop_ff         <= drop_in;
         slot_state_ff   <= slot_state_in;
         slot_result_ff  <= slot_result_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         flight_ff <= flight_in;
      end
   end

   always_comb begin
      result.status          = status;
      result.slot_given      = slot_out;
      result.completion_code = code;
      result.attempt_made    = attempt;
      result.frame_id        = shown.id;
      result.frame_extended  = shown.ext;
      result.frame_dlc       = shown.dlc;
      result.frame_payload   = shown.data;
      result.drops           = drop_in;
      result.queue_level     = level;
   end

endmodule

FILE: design/can_tx_queue_with_completion_slots.sv
// CAN transmit queue with completion slots, top level.
// An item waits in the input register and its result is offered from the result register,
// which takes it only while free or draining. Throughput: one item per cycle while the
// result side is not stalled; all state is updated by one pass of logic between the two
// registers.
// Reset (synchronous): empties the queue, drops the in-flight frame, frees all slots, clears
// the drop count and restores tx_enable 0, device_present 0, expiry 100 ms.
module can_tx_queue_with_completion_slots import cantxq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic          item_valid_ff, item_valid_in;
   req_type       item_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff;
   logic          fire;
   logic          req_take;
   cfg_type       cfg;
   fifo_cmd_type  fifo_cmd;
   fifo_stat_type fifo_stat;
   rsp_type       result;

   // item in the input register moves on when the result register is free or draining
   assign fire      = item_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = item_valid_ff && !fire;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      item_valid_in = item_valid_ff;
      if (req_take) begin
         item_valid_in = 1'b1;
      end else if (fire) begin
         item_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= req_data;
      end
      if (fire) begin
         rsp_ff <= result;
      end
   end

   cantxq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   cantxq_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .cmd   (fifo_cmd),
      .stat  (fifo_stat)
   );

   cantxq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item      (item_ff),
      .cfg       (cfg),
      .fifo_stat (fifo_stat),
      .fifo_cmd  (fifo_cmd),
      .result    (result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
